// ----- hw/rtl/imm_pkg.sv -----
package imm_pkg;

    // Fixed field widths
    localparam int DIM_W = 4;   // dimension register width
    localparam int IDX_W = 3;   // row / column / inner index width
    localparam int VAL_W = 16;  // matrix element width
    localparam int ACC_W = 35;  // exact dot product width
    localparam int OP_W  = 2;
    localparam int CFG_W = 2;   // configuration register index width

    localparam int MAX_DIM_DEFAULT = 8;
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_START   = 2'd2
    } op_t;

    typedef enum logic [CFG_W-1:0] {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } cfg_t;

    // Tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic             first;    // first inner step of an element
        logic             lastk;    // final inner step of an element
        logic             final_el; // final element of the product
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } mac_tag_t;

endpackage

// ----- hw/rtl/imm_ram.sv -----
module imm_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/integer_matrix_multiply_top.sv -----
// Loads: one word per cycle while no result waits on a stalled sink; a load gives no result.
// Multiply: rows(A) * cols(B) * cols(A) multiply-accumulate steps, one per cycle unless
// the sink stalls, set by the single read port of each element store.
// Dimension mismatch: one error word. No new word is taken until a multiply drains.
// Reset: control, pipeline valids and output clear, dimension registers go to 8;
// the element stores keep whatever they hold and are not cleared.
module integer_matrix_multiply_top
    import imm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,

    // Configuration write port
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_index,
    input  logic [DIM_W-1:0] cfg_data,

    // Input stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // row[2:0], col[5:3], value[21:6], zero pad
    input  logic [OP_W-1:0]  s_axis_tuser,   // operation[1:0]

    // Result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // out_row[2:0], out_col[5:3], product[40:6], pad
    output logic             m_axis_tlast,   // last
    output logic             m_axis_tuser    // dim_error
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * VAL_W;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Turn a dimension register into the index of its last row or column,
    // saturating zero to one and anything above MAX_DIM to MAX_DIM.
    function automatic logic [IDX_W-1:0] last_index(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] m1;
        m1 = v - DIM_W'(1);
        if (v == '0)
            last_index = '0;
        else if (int'(v) > MAX_DIM)
            last_index = IDX_W'(MAX_DIM - 1);
        else
            last_index = m1[IDX_W-1:0];
    endfunction

    // Configuration registers
    logic [DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;

    // Sequencer
    state_t           state_reg;
    logic [IDX_W-1:0] i_reg, j_reg, k_reg;
    logic [IDX_W-1:0] ar_last_reg, ac_last_reg, bc_last_reg;

    // Pipeline: stage 1 holds the read data, stage 2 the product
    logic                     v1_reg, v2_reg;
    mac_tag_t                 t1_reg, t2_reg, t0;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    // Output register
    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_row_reg, out_col_reg;
    logic signed [ACC_W-1:0] out_prod_reg;
    logic                    out_last_reg, out_err_reg;

    // Input word fields
    op_t              in_op;
    logic [IDX_W-1:0] in_row, in_col;
    logic [VAL_W-1:0] in_value;
    logic             in_acc, in_range, mismatch;
    logic             advance;

    logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
    logic [VAL_W-1:0]  rdata_a, rdata_b;

    assign in_op    = op_t'(s_axis_tuser);
    assign in_row   = s_axis_tdata[2:0];
    assign in_col   = s_axis_tdata[5:3];
    assign in_value = s_axis_tdata[21:6];

    // Whole pipeline moves unless a result waits and the sink stalls.
    assign advance = !(out_valid_reg && !m_axis_tready);

    // Take a word only with the pipeline empty, so store writes never meet reads.
    assign s_axis_tready = (state_reg == ST_IDLE) && !v1_reg && !v2_reg && advance;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Drop writes outside the store.
    assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
    assign waddr    = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));
    assign mismatch = last_index(a_cols_reg) != last_index(b_rows_reg);

    // Row-major reads: A[i][k] and B[k][j]
    assign raddr_a = ADDR_W'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign raddr_b = ADDR_W'(int'(k_reg) * MAX_DIM + int'(j_reg));

    imm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ram_a (
        .clk  (clk),
        .we   (in_acc && in_op == OP_WRITE_A && in_range),
        .waddr(waddr),
        .wdata(in_value),
        .re   (advance),
        .raddr(raddr_a),
        .rdata(rdata_a)
    );

    imm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ram_b (
        .clk  (clk),
        .we   (in_acc && in_op == OP_WRITE_B && in_range),
        .waddr(waddr),
        .wdata(in_value),
        .re   (advance),
        .raddr(raddr_b),
        .rdata(rdata_b)
    );

    // Tag for the step whose reads issue this cycle
    always_comb
    begin
        t0.first    = (k_reg == '0);
        t0.lastk    = (k_reg == ac_last_reg);
        t0.final_el = (k_reg == ac_last_reg) && (j_reg == bc_last_reg)
                      && (i_reg == ar_last_reg);
        t0.row      = i_reg;
        t0.col      = j_reg;
    end

    // Restart the sum on the first inner step.
    always_comb
    begin
        if (t2_reg.first)
            acc_next = ACC_W'(prod_reg);
        else
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DIM_RESET;
            a_cols_reg <= DIM_RESET;
            b_rows_reg <= DIM_RESET;
            b_cols_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_t'(cfg_index))
                CFG_A_ROWS: a_rows_reg <= cfg_data;
                CFG_A_COLS: a_cols_reg <= cfg_data;
                CFG_B_ROWS: b_rows_reg <= cfg_data;
                CFG_B_COLS: b_cols_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Sequencer state, pipeline valids and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            ar_last_reg   <= '0;
            ac_last_reg   <= '0;
            bc_last_reg   <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_prod_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_err_reg   <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= v1_reg;
            out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && in_op == OP_START)
                    begin
                        if (mismatch)
                        begin
                            // One error word, nothing multiplied
                            out_valid_reg <= 1'b1;
                            out_row_reg   <= '0;
                            out_col_reg   <= '0;
                            out_prod_reg  <= '0;
                            out_last_reg  <= 1'b1;
                            out_err_reg   <= 1'b1;
                        end
                        else
                        begin
                            state_reg   <= ST_RUN;
                            i_reg       <= '0;
                            j_reg       <= '0;
                            k_reg       <= '0;
                            ar_last_reg <= last_index(a_rows_reg);
                            ac_last_reg <= last_index(a_cols_reg);
                            bc_last_reg <= last_index(b_cols_reg);
                        end
                    end
                end
                ST_RUN:
                begin
                    // Issue one step; advance k, then j, then i
                    v1_reg <= 1'b1;
                    if (k_reg != ac_last_reg)
                    begin
                        k_reg <= k_reg + IDX_W'(1);
                    end
                    else
                    begin
                        k_reg <= '0;
                        if (j_reg != bc_last_reg)
                        begin
                            j_reg <= j_reg + IDX_W'(1);
                        end
                        else
                        begin
                            j_reg <= '0;
                            if (i_reg != ar_last_reg)
                                i_reg <= i_reg + IDX_W'(1);
                            else
                                state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Finished element goes to the output register
            if (v2_reg && t2_reg.lastk)
            begin
                out_valid_reg <= 1'b1;
                out_row_reg   <= t2_reg.row;
                out_col_reg   <= t2_reg.col;
                out_prod_reg  <= acc_next;
                out_last_reg  <= t2_reg.final_el;
                out_err_reg   <= 1'b0;
            end
        end
    end

    // Datapath: multiply registered, then accumulate
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t1_reg   <= t0;
            t2_reg   <= t1_reg;
            prod_reg <= $signed(rdata_a) * $signed(rdata_b);
            if (v2_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_prod_reg, out_col_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_err_reg;

endmodule

// ----- verif/tb_integer_matrix_multiply_top.sv -----
module tb_integer_matrix_multiply_top
    import imm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Operation code the block has to ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // Cycles with no accepted word before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    // Settle time once the product queue runs dry (pipeline plus margin)
    localparam int SETTLE_CYCLES = 8;
    // Stop the random part once this many words have gone in
    localparam int WORD_TARGET = 212;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [ACC_W-1:0] product;
        logic             last;
        logic             dim_error;
    } product_word_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0] cfg_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [23:0]      s_axis_tdata = '0;   // row[2:0], col[5:3], value[21:6], zero pad
    logic [OP_W-1:0]  s_axis_tuser = '0;   // operation[1:0]
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [47:0]      m_axis_tdata;        // out_row[2:0], out_col[5:3], product[40:6], pad
    logic             m_axis_tlast;        // last
    logic             m_axis_tuser;        // dim_error

    integer_matrix_multiply_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the block: both element stores, which entries hold data,
    // and the four dimension registers as last written.
    logic signed [VAL_W-1:0] mat_a [64];
    logic signed [VAL_W-1:0] mat_b [64];
    bit                      a_written [64];
    bit                      b_written [64];
    logic [DIM_W-1:0]        reg_a_rows = DIM_RESET;
    logic [DIM_W-1:0]        reg_a_cols = DIM_RESET;
    logic [DIM_W-1:0]        reg_b_rows = DIM_RESET;
    logic [DIM_W-1:0]        reg_b_cols = DIM_RESET;

    // Product words still owed by the block, oldest first
    product_word_t product_q [$];

    int err_cnt = 0;
    int words_sent = 0;
    int send_gap = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Saturate a raw register value into 1..MAX_DIM
    function automatic int dim_of(logic [DIM_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_DIM_DEFAULT)
            return MAX_DIM_DEFAULT;
        return int'(raw);
    endfunction

    // Idle count for one word; a burst stretch forces zero
    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    // Weight the element values toward the extremes now and then
    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($signed($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    // Apply one accepted word to the shadow state and queue the products it causes
    function automatic void predict_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] r,
                                         logic [IDX_W-1:0] c, logic [VAL_W-1:0] v);
        product_word_t w;
        int ar;
        int ac;
        int br;
        int bc;
        longint acc;

        ar = dim_of(reg_a_rows);
        ac = dim_of(reg_a_cols);
        br = dim_of(reg_b_rows);
        bc = dim_of(reg_b_cols);
        case (op)
            OP_WRITE_A:
            begin
                mat_a[{r, c}] = v;
                a_written[{r, c}] = 1'b1;
            end
            OP_WRITE_B:
            begin
                mat_b[{r, c}] = v;
                b_written[{r, c}] = 1'b1;
            end
            OP_START:
            begin
                if (ac != br)
                begin
                    w = '{row: '0, col: '0, product: '0, last: 1'b1, dim_error: 1'b1};
                    product_q.push_back(w);
                end
                else
                begin
                    for (int i = 0; i < ar; i++)
                    begin
                        for (int j = 0; j < bc; j++)
                        begin
                            acc = 0;
                            for (int k = 0; k < ac; k++)
                                acc += longint'(mat_a[6'(i * 8 + k)])
                                       * longint'(mat_b[6'(k * 8 + j)]);
                            w.row       = 3'(i);
                            w.col       = 3'(j);
                            w.product   = ACC_W'(acc);
                            w.last      = (i == ar - 1) && (j == bc - 1);
                            w.dim_error = 1'b0;
                            product_q.push_back(w);
                        end
                    end
                end
            end
            default:
            begin
                // unused code: no effect
            end
        endcase
    endfunction

    // Present one word after a random gap, hold it until accepted, then predict.
    // Keep valid high when the next word follows with no gap.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c, input logic [VAL_W-1:0] v);
        repeat (send_gap) @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, v, c, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_word(op, r, c, v);
        words_sent++;
        if ($urandom_range(0, 15) == 0)
            send_burst = !send_burst;
        send_gap = draw_wait(send_burst);
        if (send_gap != 0)
            s_axis_tvalid <= 1'b0;
    endtask

    // Drop valid if the last word left it high
    task automatic stream_pause();
        if (send_gap == 0)
            s_axis_tvalid <= 1'b0;
    endtask

    // Hold the sender until every owed product word has come back
    task automatic drain_products();
        stream_pause();
        do
            @(posedge clk);
        while (product_q.size() != 0);
    endtask

    task automatic write_reg(input cfg_t idx, input logic [DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_A_ROWS: reg_a_rows = val;
            CFG_A_COLS: reg_a_cols = val;
            CFG_B_ROWS: reg_b_rows = val;
            CFG_B_COLS: reg_b_cols = val;
            default:    ;
        endcase
    endtask

    // Change the dimensions only once the block has gone quiet
    task automatic set_dims(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
                            input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc);
        drain_products();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_A_ROWS, ar);
        write_reg(CFG_A_COLS, ac);
        write_reg(CFG_B_ROWS, br);
        write_reg(CFG_B_COLS, bc);
        cfg_we <= 1'b0;
    endtask

    // Write every element the next multiply reads that still holds nothing,
    // so no unwritten entry is ever read.
    task automatic load_missing();
        int ar;
        int ac;
        int bc;

        ar = dim_of(reg_a_rows);
        ac = dim_of(reg_a_cols);
        bc = dim_of(reg_b_cols);
        if (ac != dim_of(reg_b_rows))
            return;
        for (int i = 0; i < ar; i++)
            for (int k = 0; k < ac; k++)
                if (!a_written[6'(i * 8 + k)])
                    send_word(OP_WRITE_A, 3'(i), 3'(k), rand_value());
        for (int k = 0; k < ac; k++)
            for (int j = 0; j < bc; j++)
                if (!b_written[6'(k * 8 + j)])
                    send_word(OP_WRITE_B, 3'(k), 3'(j), rand_value());
    endtask

    task automatic start_product();
        load_missing();
        send_word(OP_START, 3'($urandom), 3'($urandom), 16'($urandom));
    endtask

    // 1x8 by 8x1 with every element at the most negative value:
    // the sum reaches 2^33, the largest dot product the inputs allow.
    task automatic test_extreme_sum();
        set_dims(4'd1, 4'd8, 4'd8, 4'd1);
        for (int k = 0; k < 8; k++)
        begin
            send_word(OP_WRITE_A, 3'd0, 3'(k), 16'h8000);
            send_word(OP_WRITE_B, 3'(k), 3'd0, 16'h8000);
        end
        send_word(OP_START, 3'd0, 3'd0, 16'h0000);
    endtask

    // Full 8x8 by 8x8: fill both stores and take all 64 product words
    task automatic test_full_product();
        set_dims(4'd8, 4'd8, 4'd8, 4'd8);
        start_product();
    endtask

    // Register zero reads as one and values above eight saturate; an unused
    // operation code must leave the stores alone.
    task automatic test_clamped_dims();
        set_dims(4'd0, 4'd15, 4'd8, 4'd0);
        send_word(OP_WRITE_A, 3'd0, 3'd7, 16'h7fff);
        send_word(OP_WRITE_B, 3'd7, 3'd0, 16'h7fff);
        send_word(OP_START, 3'd7, 3'd7, 16'hffff);
        drain_products();
        send_word(OP_UNUSED, 3'd0, 3'd7, 16'h5a5a);
        send_word(OP_START, 3'd0, 3'd0, 16'h0000);
    endtask

    // Inner dimensions that disagree give one error word
    task automatic test_dim_mismatch();
        set_dims(4'd8, 4'd3, 4'd5, 4'd8);
        send_word(OP_START, 3'd0, 3'd0, 16'h0000);
        set_dims(4'd1, 4'd0, 4'd2, 4'd1);
        send_word(OP_START, 3'd0, 3'd0, 16'h0000);
    endtask

    // Random shapes, mostly small, with loads, noise and multiplies mixed
    task automatic test_random_products();
        int dim [4];
        logic [DIM_W-1:0] raw [4];
        int n_ops;
        int pick;
        bit to_a;
        int rows;
        int cols;

        while (words_sent < WORD_TARGET)
        begin
            for (int m = 0; m < 4; m++)
                dim[m] = ($urandom_range(0, 7) == 0) ? MAX_DIM_DEFAULT : $urandom_range(1, 4);
            if ($urandom_range(0, 9) == 0)
                foreach (dim[m])
                    dim[m] = MAX_DIM_DEFAULT;
            if ($urandom_range(0, 5) == 0)
            begin
                // force a mismatch on the inner dimension
                while (dim[2] == dim[1])
                    dim[2] = $urandom_range(1, MAX_DIM_DEFAULT);
            end
            else
                dim[2] = dim[1];
            // encode through the out-of-range register values now and then
            for (int m = 0; m < 4; m++)
            begin
                raw[m] = DIM_W'(dim[m]);
                if (dim[m] == 1 && $urandom_range(0, 2) == 0)
                    raw[m] = '0;
                if (dim[m] == MAX_DIM_DEFAULT && $urandom_range(0, 2) == 0)
                    raw[m] = DIM_W'($urandom_range(9, 15));
            end
            set_dims(raw[0], raw[1], raw[2], raw[3]);

            n_ops = $urandom_range(2, 10);
            repeat (n_ops)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 11)
                begin
                    to_a = 1'($urandom_range(0, 1));
                    rows = to_a ? dim[0] : dim[2];
                    cols = to_a ? dim[1] : dim[3];
                    // mostly inside the live region, sometimes anywhere
                    if ($urandom_range(0, 3) == 0)
                    begin
                        rows = 8;
                        cols = 8;
                    end
                    send_word(to_a ? OP_WRITE_A : OP_WRITE_B,
                              3'($urandom_range(0, rows - 1)),
                              3'($urandom_range(0, cols - 1)), rand_value());
                end
                else if (pick < 13)
                    send_word(OP_UNUSED, 3'($urandom), 3'($urandom), 16'($urandom));
                else if (pick < 14)
                    drain_products();
                else
                    start_product();
            end
            start_product();
        end
    endtask

    // Result side: random stalls on ready, and compare every accepted word
    // with the oldest owed product word.
    task automatic check_field(input string name, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
        if (want !== got)
        begin
            err_cnt++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    initial
    begin
        product_word_t want;
        int recv_stall;

        recv_stall = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (product_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected word expected none actual %h last %b err %b",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
                else
                begin
                    want = product_q.pop_front();
                    check_field("out_row", ACC_W'(want.row), ACC_W'(m_axis_tdata[2:0]));
                    check_field("out_col", ACC_W'(want.col), ACC_W'(m_axis_tdata[5:3]));
                    check_field("product", want.product, m_axis_tdata[40:6]);
                    check_field("last", ACC_W'(want.last), ACC_W'(m_axis_tlast));
                    check_field("dim_error", ACC_W'(want.dim_error), ACC_W'(m_axis_tuser));
                end
                if ($urandom_range(0, 15) == 0)
                    recv_burst = !recv_burst;
                recv_stall = draw_wait(recv_burst);
                if (recv_stall != 0)
                    m_axis_tready <= 1'b0;
            end
            else if (!m_axis_tready)
            begin
                if (recv_stall > 1)
                    recv_stall--;
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no word moves on any port for too long
    initial
    begin
        int idle_cycles;

        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_integer_matrix_multiply_top: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_sum();
        test_full_product();
        test_clamped_dims();
        test_dim_mismatch();
        test_random_products();

        // let the last multiply drain, then allow the pipeline to settle
        drain_products();
        repeat (SETTLE_CYCLES * 4) @(posedge clk);
        if (err_cnt == 0 && product_q.size() == 0)
            $display("tb_integer_matrix_multiply_top: done, clean");
        else
            $display("tb_integer_matrix_multiply_top: done, errors");
        $finish;
    end

endmodule

// ----- integer_matrix_multiply_top.f -----
hw/rtl/imm_pkg.sv
hw/rtl/imm_ram.sv
hw/rtl/integer_matrix_multiply_top.sv
verif/tb_integer_matrix_multiply_top.sv
